/* rtl/srtdc_pkg.sv */
// Shared types, constants and helpers for the sorted relocation table delta coder.
`timescale 1ns / 1ps
`default_nettype none
package srtdc_pkg;

   localparam int TABLE_DEPTH_DEF = 1024;

   localparam int ADDR_W    = 32;
   localparam int IDX_W     = 30;
   localparam int MODE_W    = 8;
   localparam int ENTRY_W   = IDX_W + MODE_W;
   localparam int STATUS_W  = 2;
   localparam int TAG_W     = 8;
   localparam int NBYTES_W  = 3;
   localparam int COUNT_W   = 11;
   localparam int SECTION_W = 13;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 72;

   // rsp_tdata field offsets
   localparam int RSP_STATUS_LSB  = 0;
   localparam int RSP_TAG_LSB     = RSP_STATUS_LSB + STATUS_W;
   localparam int RSP_DELTA_LSB   = RSP_TAG_LSB + TAG_W;
   localparam int RSP_NBYTES_LSB  = RSP_DELTA_LSB + IDX_W;
   localparam int RSP_COUNT_LSB   = RSP_NBYTES_LSB + NBYTES_W;
   localparam int RSP_SECTION_LSB = RSP_COUNT_LSB + COUNT_W;
   localparam int RSP_USED_W      = RSP_SECTION_LSB + SECTION_W;

   localparam int TREE_RADIX_LOG = 4;
   localparam int TREE_RADIX     = 1 << TREE_RADIX_LOG;

   localparam logic [IDX_W-1:0]     ONE_BYTE_LIMIT = 30'd256;
   localparam logic [IDX_W-1:0]     TWO_BYTE_LIMIT = 30'd65536;
   localparam logic [SECTION_W-1:0] SECTION_RESET  = 13'd4;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_READ   = 2'd1,
      CMD_REWIND = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_MISALIGNED = 2'd1,
      STATUS_FULL       = 2'd2,
      STATUS_NO_RECORD  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_LOOKUP,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic              insert_en;
      logic [IDX_W-1:0]  idx;
      logic [MODE_W-1:0] mode;
   } bcast_type;

   function automatic int tree_levels(input int depth);
      int lv;
      lv = ($clog2(depth) + TREE_RADIX_LOG - 1) / TREE_RADIX_LOG;
      return (lv < 1) ? 1 : lv;
   endfunction

   function automatic logic [MODE_W-1:0] mode_code(input logic undef, input logic absl);
      logic [MODE_W-1:0] code;
      case ({absl, undef})
         2'b10:   code = 8'd0;
         2'b11:   code = 8'd1;
         2'b00:   code = 8'd255;
         default: code = 8'd2;
      endcase
      return code;
   endfunction

endpackage
`default_nettype wire

/* rtl/srtdc_cell.sv */
// One table cell: holds one sorted entry and shifts it up on an insert below it.
`timescale 1ns / 1ps
`default_nettype none
module srtdc_cell #(
   parameter int INDEX = 0,
   parameter int CW    = 11
) (
   input  wire                                clock,
   input  wire  srtdc_pkg::bcast_type         bcast,
   input  wire  [CW-1:0]                      total,
   input  wire  [CW-1:0]                      read_pos,
   input  wire                                prev_greater,
   input  wire  [srtdc_pkg::IDX_W-1:0]        prev_word,
   input  wire  [srtdc_pkg::MODE_W-1:0]       prev_mode,
   output logic                               greater,
   output logic [srtdc_pkg::IDX_W-1:0]        word,
   output logic [srtdc_pkg::MODE_W-1:0]       mode,
   output logic [srtdc_pkg::ENTRY_W-1:0]      rd_data
);

   logic [srtdc_pkg::IDX_W-1:0]  word_ff;
   logic [srtdc_pkg::MODE_W-1:0] mode_ff;
   logic                         occupied_w;
   logic                         tail_w;
   logic                         load_new_w;
   logic                         shift_w;

   assign occupied_w = CW'(INDEX) < total;
   assign tail_w     = total == CW'(INDEX);
   assign greater    = occupied_w && (bcast.idx < word_ff);
   assign load_new_w = bcast.insert_en && (greater || tail_w) && !prev_greater;
   assign shift_w    = bcast.insert_en && prev_greater;

   always_ff @(posedge clock) begin
      if (shift_w) begin
         word_ff <= prev_word;
         mode_ff <= prev_mode;
      end else if (load_new_w) begin
         word_ff <= bcast.idx;
         mode_ff <= bcast.mode;
      end
   end

   assign word    = word_ff;
   assign mode    = mode_ff;
   assign rd_data = (read_pos == CW'(INDEX)) ? {mode_ff, word_ff} : '0;

endmodule
`default_nettype wire

/* rtl/srtdc_read_tree.sv */
// Registered radix-16 OR tree that collects the selected cell's entry.
`timescale 1ns / 1ps
`default_nettype none
module srtdc_read_tree #(
   parameter int DEPTH = srtdc_pkg::TABLE_DEPTH_DEF
) (
   input  wire                                clock,
   input  wire  [srtdc_pkg::ENTRY_W-1:0]      leaf [DEPTH],
   output logic [srtdc_pkg::ENTRY_W-1:0]      root
);

   localparam int RL     = srtdc_pkg::TREE_RADIX_LOG;
   localparam int RADIX  = srtdc_pkg::TREE_RADIX;
   localparam int LEVELS = srtdc_pkg::tree_levels(DEPTH);
   localparam int LEAF   = 1 << (RL * LEVELS);

   function automatic int nodes_at(input int lvl);
      return 1 << (RL * (LEVELS - lvl));
   endfunction

   function automatic int node_off(input int lvl);
      int sum;
      sum = 0;
      for (int m = 1; m < lvl; m++) begin
         sum = sum + nodes_at(m);
      end
      return sum;
   endfunction

   localparam int TOTAL = node_off(LEVELS) + 1;

   logic [srtdc_pkg::ENTRY_W-1:0] pad_w  [LEAF];
   logic [srtdc_pkg::ENTRY_W-1:0] node_ff [TOTAL];

   for (genvar k = 0; k < LEAF; k++) begin : g_pad
      if (k < DEPTH) begin : g_used
         assign pad_w[k] = leaf[k];
      end else begin : g_zero
         assign pad_w[k] = '0;
      end
   end

   for (genvar j = 1; j <= LEVELS; j++) begin : g_lvl
      for (genvar i = 0; i < nodes_at(j); i++) begin : g_node
         logic [srtdc_pkg::ENTRY_W-1:0] acc_w;
         always_comb begin
            acc_w = '0;
            for (int c = 0; c < RADIX; c++) begin
               if (j == 1) begin
                  acc_w = acc_w | pad_w[RADIX * i + c];
               end else begin
                  acc_w = acc_w | node_ff[node_off(j - 1) + RADIX * i + c];
               end
            end
         end
         always_ff @(posedge clock) begin
            node_ff[node_off(j) + i] <= acc_w;
         end
      end
   end

   assign root = node_ff[TOTAL - 1];

endmodule
`default_nettype wire

/* rtl/sorted_relocation_table_delta_coder_top.sv */
// Top level of the sorted relocation table delta coder: cell chain, read tree, control.
//
//  channel | direction | transfer contents
//  req_    | in        | tuser: command; tdata: address, undefined_symbol, absolute
//  rsp_    | out       | tdata: status..section_bytes; tlast: last_record
//
// An insert goes through accept, an EXEC state in which every cell compares and shifts, finish.
// A read with a record waits in LOOKUP on L = ceil(log16(TABLE_DEPTH)) tree levels (3 at 1024).
// Reset clears counters and control; table contents are undefined until inserted.
// A new request is taken while a result waits in the output register; a result
// finished while rsp_tready is low holds the engine until the register is free.
`timescale 1ns / 1ps
`default_nettype none
module sorted_relocation_table_delta_coder_top #(
   parameter int TABLE_DEPTH = srtdc_pkg::TABLE_DEPTH_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // [31:0] address, [32] undefined_symbol, [33] absolute
   input  wire  [srtdc_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // [1:0] command
   input  wire  [1:0]                           req_tuser,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // [1:0] status, [9:2] tag_byte, [39:10] delta, [42:40] delta_bytes,
   // [53:43] entry_count, [66:54] section_bytes
   output logic [srtdc_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                                 rsp_tlast
);

   localparam int CW     = $clog2(TABLE_DEPTH + 1);
   localparam int LEVELS = srtdc_pkg::tree_levels(TABLE_DEPTH);
   localparam int WW     = $clog2(LEVELS + 1);
   localparam int IW     = srtdc_pkg::IDX_W;
   localparam int MW     = srtdc_pkg::MODE_W;
   localparam int SW     = srtdc_pkg::SECTION_W;

   srtdc_pkg::state_type state_ff, state_in;

   srtdc_pkg::cmd_type          cmd_ff;
   logic [srtdc_pkg::ADDR_W-1:0] addr_ff;
   logic                        undef_ff;
   logic                        absl_ff;

   logic [CW-1:0]  total_ff;
   logic [CW-1:0]  rdpos_ff;
   logic [IW-1:0]  prev_ff;
   logic [SW-1:0]  bytes_ff;
   logic [WW-1:0]  wait_ff;

   srtdc_pkg::status_type           rec_status_ff;
   logic [srtdc_pkg::TAG_W-1:0]     rec_tag_ff;
   logic [IW-1:0]                   rec_delta_ff;
   logic [srtdc_pkg::NBYTES_W-1:0]  rec_nb_ff;
   logic                            rec_read_ff;

   logic                            rsp_valid_ff;
   logic [srtdc_pkg::RSP_TDATA_W-1:0] rsp_data_ff;
   logic                            rsp_last_ff;

   logic full_w, past_end_w, out_free_w, insert_en_w, rsp_load_w, ready_w;
   srtdc_pkg::bcast_type bcast_w;

   logic [CW+srtdc_pkg::COUNT_W-1:0] count_ext_w;

   logic                  greater_w [TABLE_DEPTH];
   logic [IW-1:0]         word_w    [TABLE_DEPTH];
   logic [MW-1:0]         mode_w    [TABLE_DEPTH];
   logic [srtdc_pkg::ENTRY_W-1:0] rd_w [TABLE_DEPTH];
   logic [srtdc_pkg::ENTRY_W-1:0] root_w;

   logic [IW-1:0]  delta_w;
   logic [1:0]     cls_w;
   logic [srtdc_pkg::NBYTES_W-1:0] nb_w;

   assign full_w     = total_ff == CW'(TABLE_DEPTH);
   assign past_end_w = rdpos_ff >= total_ff;
   assign out_free_w = !rsp_valid_ff || rsp_tready;

   assign bcast_w.insert_en = insert_en_w;
   assign bcast_w.idx       = addr_ff[srtdc_pkg::ADDR_W-1:2];
   assign bcast_w.mode      = srtdc_pkg::mode_code(undef_ff, absl_ff);

   for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
      if (k == 0) begin : g_first
         srtdc_cell #(.INDEX(k), .CW(CW)) u_cell (
            .clock        (clock),
            .bcast        (bcast_w),
            .total        (total_ff),
            .read_pos     (rdpos_ff),
            .prev_greater (1'b0),
            .prev_word    ({IW{1'b0}}),
            .prev_mode    ({MW{1'b0}}),
            .greater      (greater_w[k]),
            .word         (word_w[k]),
            .mode         (mode_w[k]),
            .rd_data      (rd_w[k])
         );
      end else begin : g_rest
         srtdc_cell #(.INDEX(k), .CW(CW)) u_cell (
            .clock        (clock),
            .bcast        (bcast_w),
            .total        (total_ff),
            .read_pos     (rdpos_ff),
            .prev_greater (greater_w[k-1]),
            .prev_word    (word_w[k-1]),
            .prev_mode    (mode_w[k-1]),
            .greater      (greater_w[k]),
            .word         (word_w[k]),
            .mode         (mode_w[k]),
            .rd_data      (rd_w[k])
         );
      end
   end

   srtdc_read_tree #(.DEPTH(TABLE_DEPTH)) u_tree (
      .clock (clock),
      .leaf  (rd_w),
      .root  (root_w)
   );

   // record coding from the tree output
   assign delta_w = root_w[IW-1:0] - prev_ff;
   always_comb begin
      if (delta_w < srtdc_pkg::ONE_BYTE_LIMIT) begin
         cls_w = 2'd0;
         nb_w  = 3'd1;
      end else if (delta_w < srtdc_pkg::TWO_BYTE_LIMIT) begin
         cls_w = 2'd1;
         nb_w  = 3'd2;
      end else begin
         cls_w = 2'd2;
         nb_w  = 3'd4;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         srtdc_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = srtdc_pkg::ST_EXEC;
         end
         srtdc_pkg::ST_EXEC: begin
            if (cmd_ff == srtdc_pkg::CMD_READ && !past_end_w) begin
               state_in = srtdc_pkg::ST_LOOKUP;
            end else begin
               state_in = srtdc_pkg::ST_FINISH;
            end
         end
         srtdc_pkg::ST_LOOKUP: begin
            if (wait_ff == '0) state_in = srtdc_pkg::ST_FINISH;
         end
         srtdc_pkg::ST_FINISH: begin
            if (out_free_w) state_in = srtdc_pkg::ST_IDLE;
         end
         default: state_in = srtdc_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      ready_w     = 1'b0;
      insert_en_w = 1'b0;
      rsp_load_w  = 1'b0;
      unique case (state_ff)
         srtdc_pkg::ST_IDLE:   ready_w = 1'b1;
         srtdc_pkg::ST_EXEC:   insert_en_w = (cmd_ff == srtdc_pkg::CMD_INSERT) && !full_w;
         srtdc_pkg::ST_LOOKUP: ;
         srtdc_pkg::ST_FINISH: rsp_load_w = out_free_w;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srtdc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (ready_w && req_tvalid) begin
         cmd_ff   <= srtdc_pkg::cmd_type'(req_tuser);
         addr_ff  <= req_tdata[srtdc_pkg::ADDR_W-1:0];
         undef_ff <= req_tdata[srtdc_pkg::ADDR_W];
         absl_ff  <= req_tdata[srtdc_pkg::ADDR_W+1];
      end
   end

   // table counters and read state
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         rdpos_ff <= '0;
         prev_ff  <= '0;
         bytes_ff <= srtdc_pkg::SECTION_RESET;
      end else begin
         if (insert_en_w) total_ff <= total_ff + CW'(1);
         if (state_ff == srtdc_pkg::ST_EXEC && cmd_ff == srtdc_pkg::CMD_REWIND) begin
            rdpos_ff <= '0;
            prev_ff  <= '0;
            bytes_ff <= srtdc_pkg::SECTION_RESET;
         end
         if (state_ff == srtdc_pkg::ST_LOOKUP && wait_ff == '0) begin
            rdpos_ff <= rdpos_ff + CW'(1);
            prev_ff  <= root_w[IW-1:0];
            bytes_ff <= bytes_ff + SW'(1) + SW'(nb_w);
         end
      end
   end

   // record fields
   always_ff @(posedge clock) begin
      if (state_ff == srtdc_pkg::ST_EXEC) begin
         wait_ff      <= WW'(LEVELS - 1);
         rec_tag_ff   <= '0;
         rec_delta_ff <= '0;
         rec_nb_ff    <= '0;
         rec_read_ff  <= 1'b0;
         unique case (cmd_ff)
            srtdc_pkg::CMD_INSERT: begin
               if (full_w) begin
                  rec_status_ff <= srtdc_pkg::STATUS_FULL;
               end else if (addr_ff[1:0] != 2'b00) begin
                  rec_status_ff <= srtdc_pkg::STATUS_MISALIGNED;
               end else begin
                  rec_status_ff <= srtdc_pkg::STATUS_OK;
               end
            end
            srtdc_pkg::CMD_READ: begin
               rec_status_ff <= past_end_w ? srtdc_pkg::STATUS_NO_RECORD
                                           : srtdc_pkg::STATUS_OK;
            end
            default: rec_status_ff <= srtdc_pkg::STATUS_OK;
         endcase
      end else if (state_ff == srtdc_pkg::ST_LOOKUP) begin
         wait_ff <= wait_ff - WW'(1);
         if (wait_ff == '0) begin
            rec_tag_ff   <= {cls_w, 6'b000000} | root_w[srtdc_pkg::ENTRY_W-1:IW];
            rec_delta_ff <= delta_w;
            rec_nb_ff    <= nb_w;
            rec_read_ff  <= 1'b1;
         end
      end
   end

   assign count_ext_w = {{srtdc_pkg::COUNT_W{1'b0}}, total_ff};

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load_w) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load_w) begin
         rsp_data_ff <= {{(srtdc_pkg::RSP_TDATA_W - srtdc_pkg::RSP_USED_W){1'b0}},
                         bytes_ff, count_ext_w[srtdc_pkg::COUNT_W-1:0], rec_nb_ff,
                         rec_delta_ff, rec_tag_ff, rec_status_ff};
         rsp_last_ff <= rec_read_ff && (rdpos_ff == total_ff);
      end
   end

   assign req_tready = ready_w && !reset;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire

/* rtl/srtdc_checker.sv */
// Port-level assertions for the sorted relocation table delta coder, with bind.
`timescale 1ns / 1ps
`default_nettype none
module srtdc_checker (
   input wire                               clock,
   input wire                               reset,
   input wire                               rsp_tvalid,
   input wire                               rsp_tready,
   input wire [srtdc_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input wire                               rsp_tlast
);

   logic [srtdc_pkg::STATUS_W-1:0] status_w;
   logic [srtdc_pkg::NBYTES_W-1:0] nb_w;
   logic [1:0]                     cls_w;
   logic [srtdc_pkg::TAG_W-1:0]    tag_w;

   assign status_w = rsp_tdata[srtdc_pkg::RSP_STATUS_LSB +: srtdc_pkg::STATUS_W];
   assign nb_w     = rsp_tdata[srtdc_pkg::RSP_NBYTES_LSB +: srtdc_pkg::NBYTES_W];
   assign tag_w    = rsp_tdata[srtdc_pkg::RSP_TAG_LSB +: srtdc_pkg::TAG_W];
   assign cls_w    = tag_w[7:6];

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_last_is_record: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> status_w == srtdc_pkg::STATUS_OK && nb_w != 3'd0)
      else $error("last record without a record");

   a_no_record_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status_w != srtdc_pkg::STATUS_OK |-> nb_w == 3'd0 && !rsp_tlast)
      else $error("record fields on a non-ok result");

   a_size_class: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && nb_w != 3'd0 |->
         tag_w == 8'd255 || (nb_w == 3'd1 && cls_w == 2'd0) ||
         (nb_w == 3'd2 && cls_w == 2'd1) || (nb_w == 3'd4 && cls_w == 2'd2))
      else $error("tag size class disagrees with delta bytes");

endmodule

bind sorted_relocation_table_delta_coder_top srtdc_checker u_srtdc_checker (.*);
`default_nettype wire

/* dv/tb.sv */
// Self-checking testbench for the sorted relocation table delta coder.
`timescale 1ns / 1ps

localparam logic [1:0]                   CMD_UNUSED     = 2'd3;
localparam logic [srtdc_pkg::MODE_W-1:0] MODE_DEF_ABS   = 8'd0;
localparam logic [srtdc_pkg::MODE_W-1:0] MODE_UNDEF_ABS = 8'd1;
localparam logic [srtdc_pkg::MODE_W-1:0] MODE_DEF_REL   = 8'd255;
localparam logic [srtdc_pkg::MODE_W-1:0] MODE_UNDEF_REL = 8'd2;

typedef struct {
   srtdc_pkg::status_type             status;
   logic [srtdc_pkg::TAG_W-1:0]       tag;
   logic [srtdc_pkg::IDX_W-1:0]       delta;
   logic [srtdc_pkg::NBYTES_W-1:0]    nbytes;
   logic [srtdc_pkg::COUNT_W-1:0]     count;
   logic                              last;
   logic [srtdc_pkg::SECTION_W-1:0]   section;
} reloc_record_type;

class reloc_scoreboard_type;
   logic [srtdc_pkg::IDX_W-1:0]     word_idx [srtdc_pkg::TABLE_DEPTH_DEF];
   logic [srtdc_pkg::MODE_W-1:0]    mode_of [srtdc_pkg::TABLE_DEPTH_DEF];
   int unsigned                     entries;
   int unsigned                     read_pos;
   logic [srtdc_pkg::IDX_W-1:0]     prev_idx;
   logic [srtdc_pkg::SECTION_W-1:0] section_len;
   reloc_record_type                expected_records[$];
   int unsigned                     failures, mismatches, n_checked;
   int unsigned                     n_insert, n_full, n_read, n_past_end, n_rewind, n_unused;
   int unsigned                     n_size[3];

   function new();
      entries = 0;
      read_pos = 0;
      prev_idx = '0;
      section_len = srtdc_pkg::SECTION_RESET;
      failures = 0;
      mismatches = 0;
      n_checked = 0;
      n_insert = 0;
      n_full = 0;
      n_read = 0;
      n_past_end = 0;
      n_rewind = 0;
      n_unused = 0;
      n_size = '{0, 0, 0};
   endfunction

   function int unsigned pending();
      return expected_records.size();
   endfunction

   // Accepted request: update the table model and queue the expected response.
   function void note_request(logic [1:0] cmd, logic [srtdc_pkg::ADDR_W-1:0] addr,
                              logic undef, logic absl);
      reloc_record_type            rec;
      logic [srtdc_pkg::IDX_W-1:0] idx;
      logic [1:0]                  size_class;
      int unsigned                 pos;
      rec.status = srtdc_pkg::STATUS_OK;
      rec.tag = '0;
      rec.delta = '0;
      rec.nbytes = '0;
      rec.last = 1'b0;
      case (cmd)
         srtdc_pkg::CMD_INSERT: begin
            n_insert++;
            if (entries >= srtdc_pkg::TABLE_DEPTH_DEF) begin
               rec.status = srtdc_pkg::STATUS_FULL;
               n_full++;
            end else begin
               idx = addr[srtdc_pkg::ADDR_W-1:2];
               pos = entries;
               // equal indices stay ahead of the new entry
               while (pos > 0 && idx < word_idx[pos-1]) begin
                  word_idx[pos] = word_idx[pos-1];
                  mode_of[pos] = mode_of[pos-1];
                  pos--;
               end
               word_idx[pos] = idx;
               if (absl)
                  mode_of[pos] = undef ? MODE_UNDEF_ABS : MODE_DEF_ABS;
               else
                  mode_of[pos] = undef ? MODE_UNDEF_REL : MODE_DEF_REL;
               entries++;
               if (addr[1:0] != 2'b00)
                  rec.status = srtdc_pkg::STATUS_MISALIGNED;
            end
         end
         srtdc_pkg::CMD_READ: begin
            n_read++;
            if (read_pos >= entries) begin
               rec.status = srtdc_pkg::STATUS_NO_RECORD;
               n_past_end++;
            end else begin
               rec.delta = word_idx[read_pos] - prev_idx;
               if (rec.delta < 256)
                  size_class = 2'd0;
               else if (rec.delta < 65536)
                  size_class = 2'd1;
               else
                  size_class = 2'd2;
               rec.nbytes = (size_class == 2'd0) ? 3'd1 : (size_class == 2'd1) ? 3'd2 : 3'd4;
               rec.tag = {size_class, 6'd0} | mode_of[read_pos];
               section_len = section_len + 13'd1 + rec.nbytes;
               prev_idx = word_idx[read_pos];
               read_pos++;
               rec.last = (read_pos == entries);
               n_size[size_class]++;
            end
         end
         srtdc_pkg::CMD_REWIND: begin
            n_rewind++;
            read_pos = 0;
            prev_idx = '0;
            section_len = srtdc_pkg::SECTION_RESET;
         end
         default: begin
            n_unused++;
         end
      endcase
      rec.count = entries[srtdc_pkg::COUNT_W-1:0];
      rec.section = section_len;
      expected_records.push_back(rec);
   endfunction

   function void compare(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
         failures++;
         if (mismatches < 10)
            $display("mismatch on response %0d, %s: expected 0x%0h, got 0x%0h",
                     n_checked, field, want, got);
         mismatches++;
      end
   endfunction

   function void check_response(logic [srtdc_pkg::RSP_TDATA_W-1:0] data, logic last);
      reloc_record_type want;
      if (expected_records.size() == 0) begin
         failures++;
         if (mismatches < 10)
            $display("unexpected response 0x%0h with nothing outstanding", data);
         mismatches++;
         return;
      end
      want = expected_records.pop_front();
      n_checked++;
      compare("status", want.status,
              data[srtdc_pkg::RSP_STATUS_LSB +: srtdc_pkg::STATUS_W]);
      compare("tag_byte", want.tag, data[srtdc_pkg::RSP_TAG_LSB +: srtdc_pkg::TAG_W]);
      compare("delta", want.delta, data[srtdc_pkg::RSP_DELTA_LSB +: srtdc_pkg::IDX_W]);
      compare("delta_bytes", want.nbytes,
              data[srtdc_pkg::RSP_NBYTES_LSB +: srtdc_pkg::NBYTES_W]);
      compare("entry_count", want.count,
              data[srtdc_pkg::RSP_COUNT_LSB +: srtdc_pkg::COUNT_W]);
      compare("section_bytes", want.section,
              data[srtdc_pkg::RSP_SECTION_LSB +: srtdc_pkg::SECTION_W]);
      compare("padding", 0, data[srtdc_pkg::RSP_TDATA_W-1:srtdc_pkg::RSP_USED_W]);
      compare("last_record", want.last, last);
   endfunction

   function void report_coverage();
      $display("covered %0d responses: %0d inserts (%0d refused on a full table),",
               n_checked, n_insert, n_full);
      $display("  %0d reads (%0d past the end), %0d rewinds, %0d unused commands",
               n_read, n_past_end, n_rewind, n_unused);
      $display("records with 1/2/4-byte deltas: %0d/%0d/%0d, table ended with %0d entries",
               n_size[0], n_size[1], n_size[2], entries);
   endfunction
endclass

module tb;

   localparam int RANDOM_ITEMS = 1290;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 16;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_tvalid = 1'b0;
   wire                                req_tready;
   logic [srtdc_pkg::REQ_TDATA_W-1:0]  req_tdata = '0;
   logic [1:0]                         req_tuser = '0;
   wire                                rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   wire  [srtdc_pkg::RSP_TDATA_W-1:0]  rsp_tdata;
   wire                                rsp_tlast;

   reloc_scoreboard_type board;
   logic            no_idle = 1'b0;
   int              holds_asked = 0;
   int              holds_granted = 0;
   int              stall_left = 0;
   int              sink_gap;
   int              random_items;
   logic [31:0]     cluster_base;
   logic [31:0]     used_addrs[$];

   sorted_relocation_table_delta_coder_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      if (r < 98)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Mix of scattered, clustered, repeated and extreme relocation addresses.
   function automatic logic [31:0] next_address();
      int          r;
      logic [31:0] a;
      logic [1:0]  low;
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 19) == 0)
         cluster_base = $urandom;
      if (r < 30) begin
         a = $urandom;
      end else if (r < 60) begin
         a = cluster_base + $urandom_range(0, 2047);
      end else if (r < 80) begin
         a = cluster_base + $urandom_range(0, 1 << 22);
      end else if (r < 90 && used_addrs.size() > 0) begin
         low = 2'($urandom_range(0, 3));
         a = used_addrs[$urandom_range(0, used_addrs.size() - 1)];
         a[1:0] = low;
      end else begin
         case ($urandom_range(0, 3))
            0: a = 32'h0000_0000;
            1: a = 32'hFFFF_FFFF;
            2: a = 32'hFFFF_FFFC;
            default: a = 32'h0000_0003;
         endcase
      end
      used_addrs.push_back(a);
      return a;
   endfunction

   task automatic send(input logic [1:0] cmd, input logic [31:0] addr, input logic undef,
                       input logic absl);
      int gap;
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {{(srtdc_pkg::REQ_TDATA_W - srtdc_pkg::ADDR_W - 2){1'b0}}, absl, undef, addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(cmd, addr, undef, absl);
   endtask

   task automatic send_reads(input int n);
      repeat (n) send(srtdc_pkg::CMD_READ, $urandom, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
   endtask

   task automatic send_inserts(input int n);
      repeat (n) send(srtdc_pkg::CMD_INSERT, next_address(), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   // Response side: checks every transfer, stalls at random, honors long hold-off requests.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            board.check_response(rsp_tdata, rsp_tlast);
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else if (holds_granted != holds_asked) begin
            holds_granted <= holds_granted + 1;
            stall_left <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            sink_gap = no_idle ? 0 : pick_gap();
            if (sink_gap == 0) begin
               rsp_tready <= 1'b1;
            end else begin
               rsp_tready <= 1'b0;
               stall_left <= sink_gap - 1;
            end
         end
      end
   end

   initial begin
      #8_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      int  r;
      bit  hold_done;
      bit  pause_done;
      int  n;
      board = new();
      cluster_base = $urandom;
      hold_done = 0;
      pause_done = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: empty reads, size-class boundaries, all modes, equal index, insert mid-read
      send(srtdc_pkg::CMD_READ, 32'h0, 1'b0, 1'b0);
      send(srtdc_pkg::CMD_REWIND, 32'hFFFF_FFFF, 1'b1, 1'b1);
      send(CMD_UNUSED, 32'h1234_5678, 1'b1, 1'b0);
      send(srtdc_pkg::CMD_INSERT, 32'h0000_0000, 1'b0, 1'b1);
      send(srtdc_pkg::CMD_INSERT, 32'h0000_03FC, 1'b1, 1'b1);
      send(srtdc_pkg::CMD_INSERT, 32'h0000_07FD, 1'b0, 1'b0);
      send(srtdc_pkg::CMD_INSERT, 32'h0004_07FA, 1'b1, 1'b0);
      send(srtdc_pkg::CMD_INSERT, 32'h0008_07FB, 1'b0, 1'b1);
      send(srtdc_pkg::CMD_INSERT, 32'hFFFF_FFFF, 1'b1, 1'b0);
      send(srtdc_pkg::CMD_INSERT, 32'h0000_03FD, 1'b0, 1'b0);
      send_reads(8);
      send(srtdc_pkg::CMD_REWIND, 32'h0, 1'b0, 1'b0);
      send_reads(3);
      send(srtdc_pkg::CMD_INSERT, 32'h0000_0004, 1'b1, 1'b1);
      send_reads(2);
      wait_drained();

      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) == 0)
            no_idle <= !no_idle;
         if (!hold_done && random_items >= 400) begin
            holds_asked <= holds_asked + 1;
            hold_done = 1;
         end
         if (!pause_done && random_items >= 800) begin
            wait_drained();
            pause_done = 1;
         end
         r = $urandom_range(0, 99);
         if (board.entries < srtdc_pkg::TABLE_DEPTH_DEF &&
             RANDOM_ITEMS - random_items <= srtdc_pkg::TABLE_DEPTH_DEF - board.entries + 12)
         begin
            send_inserts(8);
            random_items += 8;
         end else if (r < 70) begin
            n = $urandom_range(1, 10);
            send_inserts(n);
            random_items += n;
         end else if (r < 88) begin
            n = $urandom_range(1, 12);
            send_reads(n);
            random_items += n;
         end else if (r < 94) begin
            n = $urandom_range(1, 12);
            send(srtdc_pkg::CMD_REWIND, $urandom, 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
            send_reads(n);
            random_items += n + 1;
         end else if (r < 96) begin
            send(CMD_UNUSED, $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end else begin
            n = $urandom_range(0, 3);
            send(n[1:0], $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            if (n[1:0] != CMD_UNUSED)
               random_items++;
         end
      end

      // full table: walk part of it again and try a misaligned insert
      send(srtdc_pkg::CMD_REWIND, 32'h0, 1'b0, 1'b0);
      send_reads(30);
      send(srtdc_pkg::CMD_INSERT, 32'h0000_0001, 1'b1, 1'b0);
      send_inserts(3);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      board.report_coverage();
      if (board.failures == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
